@@ rtl/core/string_to_integer_parser_unit_defines.svh @@
// Assertion macros for the checker file of the parser unit
`ifndef STRING_TO_INTEGER_PARSER_UNIT_DEFINES_SVH
`define STRING_TO_INTEGER_PARSER_UNIT_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted
`define SIPU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset
`define SIPU_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/sipu_pkg.sv @@
// Package: widths, register indexes and payload types of the parser unit
package sipu_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int COUNT_WIDTH = 16;
  localparam int BASE_WIDTH  = 6;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_NUMBER_BASE = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_SIGNED_MODE = CFG_INDEX_W'(1);

  typedef struct packed {
    logic [7:0] ch;
    logic       start_req;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic [COUNT_WIDTH-1:0] end_offset;
    logic                   done_res;
    logic [BASE_WIDTH-1:0]  active_base;
  } out_item_t;

  typedef struct packed {
    logic [BASE_WIDTH-1:0] number_base;
    logic                  signed_mode;
  } cfg_t;

endpackage

@@ rtl/core/sipu_core.sv @@
// Parse state registers and the per-character next-state and result logic
module sipu_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  sipu_pkg::in_item_t in_item,
  input  sipu_pkg::cfg_t     cfg,
  output sipu_pkg::out_item_t res
);
  import sipu_pkg::*;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_LEAD    = 3'd1;
  localparam logic [2:0] PH_ZERO    = 3'd2;
  localparam logic [2:0] PH_ZEROX   = 3'd3;
  localparam logic [2:0] PH_HEXZERO = 3'd4;
  localparam logic [2:0] PH_DIGITS  = 3'd5;
  localparam logic [2:0] PH_DONE    = 3'd6;

  localparam logic [BASE_WIDTH-1:0] DIGIT_BAD = '1;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = '1;

  logic [2:0]             phase_r, phase_nxt;
  logic [BASE_WIDTH-1:0]  base_r, base_nxt;
  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;
  logic                   neg_r, neg_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;

  function automatic logic [BASE_WIDTH-1:0] hex_val(input logic [7:0] c);
    logic [BASE_WIDTH-1:0] v;
    v = DIGIT_BAD;
    if (c >= "0" && c <= "9") v = BASE_WIDTH'(c - "0");
    else if (c >= "a" && c <= "f") v = BASE_WIDTH'(c - "a" + 8'd10);
    else if (c >= "A" && c <= "F") v = BASE_WIDTH'(c - "A" + 8'd10);
    return v;
  endfunction

  logic [7:0]             c;
  logic [BASE_WIDTH-1:0]  hv;
  logic                   is_x;
  logic                   lead, take;
  logic [1:0]             inc;
  logic [VALUE_WIDTH-1:0] acc_cur;
  logic [COUNT_WIDTH-1:0] cnt_cur;
  logic [COUNT_WIDTH:0]   cnt_sum;

  assign c    = in_item.ch;
  assign hv   = hex_val(c);
  assign is_x = (c == "x") || (c == "X");

  always_comb begin
    phase_nxt = phase_r;
    base_nxt  = base_r;
    acc_cur   = acc_r;
    neg_nxt   = neg_r;
    cnt_cur   = cnt_r;
    lead      = 1'b0;
    take      = 1'b0;
    inc       = 2'd0;
    if (in_item.start_req) begin
      acc_cur  = '0;
      cnt_cur  = '0;
      neg_nxt  = 1'b0;
      base_nxt = cfg.number_base;
      if (cfg.signed_mode && c == "-") begin
        neg_nxt   = 1'b1;
        inc       = 2'd1;
        phase_nxt = PH_LEAD;
      end else begin
        lead = 1'b1;
      end
    end else begin
      unique case (phase_r)
        PH_LEAD: lead = 1'b1;
        PH_ZERO: begin
          if (is_x) begin
            phase_nxt = PH_ZEROX;
          end else begin
            base_nxt = BASE_WIDTH'(8);
            take     = 1'b1;
          end
        end
        PH_ZEROX: begin
          if (hv < BASE_WIDTH'(16)) begin
            base_nxt = BASE_WIDTH'(16);
            inc      = 2'd1;
            take     = 1'b1;
          end else begin
            base_nxt  = BASE_WIDTH'(8);
            phase_nxt = PH_DONE;
          end
        end
        PH_HEXZERO: begin
          if (is_x) begin
            inc       = 2'd1;
            phase_nxt = PH_DIGITS;
          end else begin
            take = 1'b1;
          end
        end
        PH_DIGITS: take = 1'b1;
        default: ;
      endcase
    end

    if (lead) begin
      if (base_nxt == '0) begin
        if (c == "0") begin
          inc       = 2'd1;
          phase_nxt = PH_ZERO;
        end else begin
          base_nxt = BASE_WIDTH'(10);
          take     = 1'b1;
        end
      end else if (base_nxt == BASE_WIDTH'(16) && c == "0") begin
        inc       = 2'd1;
        phase_nxt = PH_HEXZERO;
      end else begin
        take = 1'b1;
      end
    end

    acc_nxt = acc_cur;
    if (take) begin
      if (hv < base_nxt) begin
        acc_nxt   = VALUE_WIDTH'(acc_cur * {{(VALUE_WIDTH-BASE_WIDTH){1'b0}}, base_nxt})
                    + {{(VALUE_WIDTH-BASE_WIDTH){1'b0}}, hv};
        inc       = inc + 2'd1;
        phase_nxt = PH_DIGITS;
      end else begin
        phase_nxt = PH_DONE;
      end
    end

    cnt_sum = {1'b0, cnt_cur} + {{(COUNT_WIDTH-1){1'b0}}, inc};
    cnt_nxt = cnt_sum[COUNT_WIDTH] ? CNT_MAX : cnt_sum[COUNT_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      base_r  <= '0;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      cnt_r   <= '0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      base_r  <= base_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign res.value       = neg_nxt ? (VALUE_WIDTH'(0) - acc_nxt) : acc_nxt;
  assign res.end_offset  = cnt_nxt;
  assign res.done_res    = (phase_nxt == PH_DONE) || (phase_nxt == PH_IDLE);
  assign res.active_base = base_nxt;

endmodule

@@ rtl/core/sipu_out_reg.sv @@
// Result register: holds one result until the receiver takes it
module sipu_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  sipu_pkg::out_item_t res_in,
  output logic                can_load,
  output logic                out_valid,
  input  logic                out_ready,
  output sipu_pkg::out_item_t out_data
);
  import sipu_pkg::*;

  logic      valid_r, valid_nxt;
  out_item_t data_r;

  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

@@ rtl/core/string_to_integer_parser_unit.sv @@
// Top level of the streaming string-to-integer parser unit
//
// Input channel (in_valid/in_ready/in_data): one character per transfer;
// in_data.start_req marks the first character of a new string.
// Result channel (out_valid/out_ready/out_data): one result per character,
// carrying the value so far, characters consumed, done flag and the base.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 is the
// number base (0 detects from prefix), index 1 enables signed mode; other
// indexes are dropped. cfg_ready is always high. Settings take effect at the
// next start character.
// Result timing: a result is valid the cycle after its character transfer.
// Throughput: one character per cycle while in_ready is high; the parse
// state and the multiply-add by the base update together on each transfer.
// Reset: parser returns to idle (done, value 0, base 0), base and signed
// mode clear to 0, the result register empties.
// Stall: the result register holds while out_ready is low; in_ready drops
// only while a result is held and out_ready is low.
module string_to_integer_parser_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  sipu_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output sipu_pkg::out_item_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sipu_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [sipu_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import sipu_pkg::*;

  cfg_t      cfg_r;
  out_item_t res;
  logic      in_fire;
  logic      can_load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_NUMBER_BASE) begin
        cfg_r.number_base <= cfg_data[BASE_WIDTH-1:0];
      end else if (cfg_index == REG_SIGNED_MODE) begin
        cfg_r.signed_mode <= cfg_data[0];
      end
    end
  end

  assign in_ready = can_load;
  assign in_fire  = in_valid && can_load;

  sipu_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_item (in_data),
    .cfg     (cfg_r),
    .res     (res)
  );

  sipu_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_fire),
    .res_in    (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ rtl/core/sipu_checker.sv @@
// Port-level assertion checker for the parser unit, bound to the top level
`include "string_to_integer_parser_unit_defines.svh"

module sipu_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input sipu_pkg::out_item_t              out_data
);
  import sipu_pkg::*;

  `SIPU_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")
  `SIPU_ASSERT_RST(a_rst_empty, !rst_n |=> !out_valid, "result valid after reset")
  `SIPU_ASSERT(a_in_to_out, in_valid && in_ready |=> out_valid, "transfer gave no result")
  `SIPU_ASSERT(a_open_counted, out_valid && !out_data.done_res |-> out_data.end_offset != 0, "open parse with zero count")

endmodule

bind string_to_integer_parser_unit sipu_checker u_sipu_checker (.*);
